// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; included by key_autorepeat_fsm.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define KAR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define KAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kar_pkg.sv -----
package kar_pkg;

    localparam int TIME_WIDTH    = 32;
    localparam int CFG_WIDTH     = 32;
    localparam int ELAPSED_WIDTH = 30;
    localparam int CFG_IDX_WIDTH = 2;

    localparam int SUM_WIDTH = ((TIME_WIDTH > ELAPSED_WIDTH) ? TIME_WIDTH : ELAPSED_WIDTH) + 1;
    localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    localparam logic [CFG_WIDTH-1:0] FIRST_DELAY_RESET    = CFG_WIDTH'(500000000);
    localparam logic [CFG_WIDTH-1:0] REPEAT_INTERVAL_RESET = CFG_WIDTH'(100000000);
    localparam logic [CFG_WIDTH-1:0] RELEASE_SETTLE_RESET  = CFG_WIDTH'(10000000);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIRST_DELAY     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RELEASE_SETTLE  = 2'd2;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_PENDING  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] first_delay;
        logic [CFG_WIDTH-1:0] repeat_interval;
        logic [CFG_WIDTH-1:0] release_settle;
    } t_cfg;

    typedef struct packed {
        t_phase                phase;
        logic [TIME_WIDTH-1:0] held;
        logic                  repeating;
        logic                  long_pressed;
    } t_state;

endpackage

// ----- rtl/key_ar_step.sv -----
module key_ar_step (
    input  kar_pkg::t_cfg                        i_cfg,
    input  kar_pkg::t_state                      i_state,
    input  logic                                 i_key_down,
    input  logic [kar_pkg::ELAPSED_WIDTH-1:0]    i_elapsed_ns,
    output kar_pkg::t_state                      o_state,
    output logic                                 o_report
);

    logic [kar_pkg::SUM_WIDTH-1:0]  sum;
    logic [kar_pkg::TIME_WIDTH-1:0] acc;
    logic [kar_pkg::CMP_WIDTH-1:0]  acc_cmp;
    logic                           hit_interval;
    logic                           hit_first;
    logic                           hit_settle;
    kar_pkg::t_phase                n_phase;

    always_comb begin
        sum = kar_pkg::SUM_WIDTH'(i_state.held) + kar_pkg::SUM_WIDTH'(i_elapsed_ns);
        if (sum > kar_pkg::SUM_WIDTH'(kar_pkg::TIME_MAX)) begin
            acc = kar_pkg::TIME_MAX;
        end else begin
            acc = kar_pkg::TIME_WIDTH'(sum);
        end
        acc_cmp      = kar_pkg::CMP_WIDTH'(acc);
        hit_interval = acc_cmp >= kar_pkg::CMP_WIDTH'(i_cfg.repeat_interval);
        hit_first    = acc_cmp >= kar_pkg::CMP_WIDTH'(i_cfg.first_delay);
        hit_settle   = acc_cmp >= kar_pkg::CMP_WIDTH'(i_cfg.release_settle);
    end

    always_comb begin
        case (i_state.phase)
            kar_pkg::PH_RELEASED: begin
                n_phase = i_key_down ? kar_pkg::PH_PRESSED : kar_pkg::PH_RELEASED;
            end
            kar_pkg::PH_PRESSED: begin
                if (i_key_down) begin
                    n_phase = kar_pkg::PH_PRESSED;
                end else if (!i_state.long_pressed) begin
                    n_phase = kar_pkg::PH_PENDING;
                end else if (hit_settle) begin
                    n_phase = kar_pkg::PH_RELEASED;
                end else begin
                    n_phase = kar_pkg::PH_PRESSED;
                end
            end
            default: begin
                n_phase = kar_pkg::PH_RELEASED;
            end
        endcase
    end

    always_comb begin
        o_state.phase        = n_phase;
        o_state.held         = acc;
        o_state.repeating    = i_state.repeating;
        o_state.long_pressed = i_state.long_pressed;
        o_report             = 1'b0;
        case (i_state.phase)
            kar_pkg::PH_RELEASED: begin
                if (i_key_down) begin
                    o_state.held = '0;
                end
            end
            kar_pkg::PH_PRESSED: begin
                if (i_key_down) begin
                    if (i_state.repeating && hit_interval) begin
                        o_report     = 1'b1;
                        o_state.held = '0;
                    end else if (!i_state.long_pressed && hit_first) begin
                        o_report             = 1'b1;
                        o_state.held         = '0;
                        o_state.repeating    = 1'b1;
                        o_state.long_pressed = 1'b1;
                    end
                end else if (!i_state.long_pressed) begin
                    o_report = 1'b1;
                end else if (hit_settle) begin
                    o_state.held         = '0;
                    o_state.repeating    = 1'b0;
                    o_state.long_pressed = 1'b0;
                end
            end
            default: begin
                o_state.held         = '0;
                o_state.repeating    = 1'b0;
                o_state.long_pressed = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/key_autorepeat_fsm.sv -----
// Each accepted tick's result is registered, into the skid entry if the output
// register is full and stalled. One tick per cycle is taken while the skid entry is empty.
// A two-entry output buffer lets one tick be taken while a result waits.
// Synchronous active-low reset returns the key to released, clears the
// time accumulator and loads the default delay, interval and settle times.
`include "assert_macros.svh"

module key_autorepeat_fsm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_key_down,
    input  logic [kar_pkg::ELAPSED_WIDTH-1:0]    i_elapsed_ns,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_report,
    output logic [1:0]                           o_phase,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kar_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [kar_pkg::CFG_WIDTH-1:0]        i_cfg_data
);

    kar_pkg::t_cfg   r_cfg;
    kar_pkg::t_state r_state;
    kar_pkg::t_state n_state;
    logic            n_report;

    logic            r_out_valid;
    logic            r_out_report;
    kar_pkg::t_phase r_out_phase;
    logic            r_skid_valid;
    logic            r_skid_report;
    kar_pkg::t_phase r_skid_phase;

    logic            accept;
    logic            pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign pop         = r_out_valid && !i_out_stall;

    key_ar_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_key_down   (i_key_down),
        .i_elapsed_ns (i_elapsed_ns),
        .o_state      (n_state),
        .o_report     (n_report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_delay     <= kar_pkg::FIRST_DELAY_RESET;
            r_cfg.repeat_interval <= kar_pkg::REPEAT_INTERVAL_RESET;
            r_cfg.release_settle  <= kar_pkg::RELEASE_SETTLE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kar_pkg::CFG_FIRST_DELAY:     r_cfg.first_delay     <= i_cfg_data;
                kar_pkg::CFG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_data;
                kar_pkg::CFG_RELEASE_SETTLE:  r_cfg.release_settle  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= kar_pkg::PH_RELEASED;
            r_state.held         <= '0;
            r_state.repeating    <= 1'b0;
            r_state.long_pressed <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= accept;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_report <= r_skid_report;
                r_out_phase  <= r_skid_phase;
            end
        end else if (!r_out_valid || pop) begin
            if (accept) begin
                r_out_report <= n_report;
                r_out_phase  <= n_state.phase;
            end
        end else if (accept) begin
            r_skid_report <= n_report;
            r_skid_phase  <= n_state.phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_report    = r_out_report;
    assign o_phase     = 2'(r_out_phase);

    `KAR_ASSERT(a_skid_needs_out, !r_skid_valid || r_out_valid,
        "Skid entry is held while the output register is empty.")
    `KAR_ASSERT_NEXT(a_pending_returns,
        accept && r_state.phase == kar_pkg::PH_PENDING,
        r_state.phase == kar_pkg::PH_RELEASED && r_state.held == '0,
        "Release pending did not return to released.")
    `KAR_ASSERT(a_report_phase,
        !(o_out_valid && o_report) || o_phase == 2'(kar_pkg::PH_PRESSED) ||
        o_phase == 2'(kar_pkg::PH_PENDING),
        "A report came with the key released.")
    `KAR_ASSERT(a_repeat_flags, !r_state.repeating || r_state.long_pressed,
        "Repeating is set without the long-press flag.")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import kar_pkg::*;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam logic [ELAPSED_WIDTH-1:0] EL_MAX     = '1;
    localparam logic [CFG_WIDTH-1:0]     CFG_MAX    = '1;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 250;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_WIDTH-1:0] index;
        logic [CFG_WIDTH-1:0]     data;
        logic                     key_down;
        logic [ELAPSED_WIDTH-1:0] elapsed;
        logic                     typed;
        logic                     report;
        t_phase                   phase;
    } t_row;

    typedef struct packed {
        logic   report;
        t_phase phase;
    } t_key_event;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     tick_valid   = 1'b0;
    logic                     tick_key     = 1'b0;
    logic [ELAPSED_WIDTH-1:0] tick_elapsed = '0;
    logic                     tick_typed   = 1'b0;
    t_key_event               tick_want    = '{1'b0, PH_RELEASED};
    logic                     rx_stall     = 1'b0;
    logic                     cfg_valid    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index    = CFG_FIRST_DELAY;
    logic [CFG_WIDTH-1:0]     cfg_data     = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_report;
    logic [1:0] o_phase;
    logic       o_cfg_ready;

    logic calm = 1'b0;
    int   stall_left = 0;
    int   mismatch_count = 0;

    // Shadow of the key machine and its timing registers.
    t_phase                key_phase;
    logic [TIME_WIDTH-1:0] held_ns;
    logic                  repeating;
    logic                  long_pressed;
    logic [CFG_WIDTH-1:0]  first_delay_ns;
    logic [CFG_WIDTH-1:0]  interval_ns;
    logic [CFG_WIDTH-1:0]  settle_ns;

    t_key_event pending_events[$];

    t_row directed_rows [0:24] = '{
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b0, 30'd0, 1'b1, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b0, EL_MAX, 1'b1, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, EL_MAX, 1'b1, 1'b0, PH_PRESSED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b0, 30'd1, 1'b1, 1'b1, PH_PENDING},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd7, 1'b1, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd0, 1'b1, 1'b0, PH_PRESSED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd499999999, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd1, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd99999999, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd1, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b0, 30'd9999999, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd90000001, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b0, 30'd10000000, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_CFG, CFG_UNUSED, CFG_MAX, 1'b0, 30'd0, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_CFG, CFG_FIRST_DELAY, 32'd0, 1'b0, 30'd0, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_CFG, CFG_REPEAT_INTERVAL, CFG_MAX, 1'b0, 30'd0, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_CFG, CFG_RELEASE_SETTLE, 32'd0, 1'b0, 30'd0, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd0, 1'b1, 1'b0, PH_PRESSED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, 30'd0, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, EL_MAX, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, EL_MAX, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, EL_MAX, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, EL_MAX, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b1, EL_MAX, 1'b0, 1'b0, PH_RELEASED},
        '{ROW_TICK, CFG_FIRST_DELAY, 32'd0, 1'b0, 30'd0, 1'b0, 1'b0, PH_RELEASED}
    };

    key_autorepeat_fsm dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (tick_valid),
        .o_in_stall   (o_in_stall),
        .i_key_down   (tick_key),
        .i_elapsed_ns (tick_elapsed),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (rx_stall),
        .o_report     (o_report),
        .o_phase      (o_phase),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        end
    endtask

    function automatic void go_released();
        held_ns      = '0;
        repeating    = 1'b0;
        long_pressed = 1'b0;
        key_phase    = PH_RELEASED;
    endfunction

    function automatic t_key_event key_event_step(input logic down,
                                                  input logic [ELAPSED_WIDTH-1:0] el);
        logic [TIME_WIDTH:0] sum;
        t_key_event          ev;
        ev.report = 1'b0;
        sum = {1'b0, held_ns} + (TIME_WIDTH + 1)'(el);
        held_ns = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
        case (key_phase)
            PH_RELEASED: begin
                if (down) begin
                    held_ns   = '0;
                    key_phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (down) begin
                    if (repeating && held_ns >= interval_ns) begin
                        ev.report = 1'b1;
                        held_ns   = '0;
                    end else if (!long_pressed && held_ns >= first_delay_ns) begin
                        ev.report    = 1'b1;
                        held_ns      = '0;
                        repeating    = 1'b1;
                        long_pressed = 1'b1;
                    end
                end else if (!long_pressed) begin
                    ev.report = 1'b1;
                    key_phase = PH_PENDING;
                end else if (held_ns >= settle_ns) begin
                    go_released();
                end
            end
            default: go_released();
        endcase
        ev.phase = key_phase;
        return ev;
    endfunction

    // Prediction and checking share one block so that a beat taken and a
    // result taken at the same edge are handled in a fixed order.
    always @(posedge i_clk) begin
        t_key_event ev;
        t_key_event want;
        if (!i_rst_n) begin
            first_delay_ns = FIRST_DELAY_RESET;
            interval_ns    = REPEAT_INTERVAL_RESET;
            settle_ns      = RELEASE_SETTLE_RESET;
            go_released();
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_DELAY:     first_delay_ns = cfg_data;
                    CFG_REPEAT_INTERVAL: interval_ns    = cfg_data;
                    CFG_RELEASE_SETTLE:  settle_ns      = cfg_data;
                    default: ;
                endcase
            end
            if (tick_valid && !o_in_stall) begin
                ev = key_event_step(tick_key, tick_elapsed);
                pending_events.push_back(tick_typed ? tick_want : ev);
            end
            if (o_out_valid && !rx_stall) begin
                if (pending_events.size() == 0) begin
                    note_mismatch("unexpected result, report", 32'(o_report), 32'd0);
                end else begin
                    want = pending_events.pop_front();
                    if (o_report !== want.report) begin
                        note_mismatch("report", 32'(o_report), 32'(want.report));
                    end
                    if (o_phase !== want.phase) begin
                        note_mismatch("phase", 32'(o_phase), 32'(want.phase));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            rx_stall   <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_stall   <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            rx_stall <= 1'b0;
        end
    end

    task automatic send_tick(input logic down, input logic [ELAPSED_WIDTH-1:0] el,
                             input logic typed, input t_key_event want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        tick_valid   <= 1'b1;
        tick_key     <= down;
        tick_elapsed <= el;
        tick_typed   <= typed;
        tick_want    <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain_events();
        tick_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_MAX;
            2:       return CFG_WIDTH'($urandom_range(1, 4000));
            3:       return CFG_WIDTH'($urandom_range(4000, 2000000));
            4:       return CFG_WIDTH'($urandom);
            default: return CFG_WIDTH'($urandom_range(10000000, 600000000));
        endcase
    endfunction

    initial begin
        logic [CFG_WIDTH-1:0]     setting [3];
        longint unsigned          top;
        int unsigned              scale;
        int                       run_left;
        logic                     key_level;
        logic                     down;
        logic [ELAPSED_WIDTH-1:0] el;
        t_row                     row;

        run_left  = 0;
        key_level = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < $size(directed_rows); r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                if (r == 0 || directed_rows[r-1].kind != ROW_CFG) begin
                    drain_events();
                end
                write_reg(row.index, row.data);
                if (r == $size(directed_rows) - 1 || directed_rows[r+1].kind != ROW_CFG) begin
                    cfg_valid <= 1'b0;
                end
            end else begin
                send_tick(row.key_down, row.elapsed, row.typed, '{row.report, row.phase});
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_events();
            calm = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 3; k++) begin
                setting[k] = (p == 1) ? '0 : (p == 2) ? CFG_MAX : pick_setting();
            end
            write_reg(CFG_FIRST_DELAY, setting[0]);
            write_reg(CFG_REPEAT_INTERVAL, setting[1]);
            write_reg(CFG_RELEASE_SETTLE, setting[2]);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_UNUSED, CFG_WIDTH'($urandom));
            end
            cfg_valid <= 1'b0;

            top = setting[0];
            if (setting[1] > top) top = setting[1];
            if (setting[2] > top) top = setting[2];
            top = top / 3 + 1;
            scale = (top > longint'(EL_MAX)) ? int'(EL_MAX) : int'(top);

            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if (run_left == 0) begin
                    key_level = !key_level;
                    if (key_level) begin
                        run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                               : $urandom_range(3, 40);
                    end else begin
                        run_left = $urandom_range(1, 6);
                    end
                end
                run_left--;
                down = ($urandom_range(0, 19) == 0) ? 1'($urandom) : key_level;
                case ($urandom_range(0, 9))
                    0:       el = '0;
                    1:       el = EL_MAX;
                    2:       el = ELAPSED_WIDTH'($urandom);
                    3:       el = ELAPSED_WIDTH'($urandom_range(0, 50));
                    default: el = ELAPSED_WIDTH'($urandom_range(0, scale));
                endcase
                send_tick(down, el, 1'b0, '{1'b0, PH_RELEASED});
            end
        end

        drain_events();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
